@@ hw/rtl/dmpi_pkg.sv @@
package dmpi_pkg;

   // Field widths fixed by the interface
   localparam int SPEED_W = 16;
   localparam int REF_W   = 16;
   localparam int ERR_W   = 17;
   localparam int GAIN_W  = 16;
   localparam int MAG_W   = 15;
   localparam int HALF_W  = 9;
   localparam int TICK_W  = 10;
   localparam int CSR_W   = 16;
   localparam int CSR_IDX_W = 2;

   // Product of an unsigned gain and a signed error
   localparam int PROD_W = GAIN_W + ERR_W + 1;

   // Register reset values
   localparam logic [MAG_W-1:0]  MAG_RESET  = '0;
   localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(256);
   localparam logic [HALF_W-1:0] HALF_RESET = HALF_W'(300);

   // Configuration register map
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_REF_MAG     = 2'd0,
      CSR_GAIN_NOW    = 2'd1,
      CSR_GAIN_PREV   = 2'd2,
      CSR_HALF_PERIOD = 2'd3
   } csr_index_type;

endpackage

@@ hw/rtl/dmpi_chan.sv @@
module dmpi_chan
   import dmpi_pkg::*;
#(
   parameter int FRAC_BITS   = 8,
   parameter int DRIVE_WIDTH = 24
) (
   input  logic signed [REF_W-1:0]       reference,
   input  logic signed [SPEED_W-1:0]     speed,
   input  logic signed [ERR_W-1:0]       prev_error,
   input  logic signed [DRIVE_WIDTH-1:0] prev_drive,
   input  logic        [GAIN_W-1:0]      gain_now,
   input  logic        [GAIN_W-1:0]      gain_prev,
   output logic signed [ERR_W-1:0]       error,
   output logic signed [DRIVE_WIDTH-1:0] drive
);

   localparam int BASE_W = (DRIVE_WIDTH + FRAC_BITS > PROD_W) ?
                           (DRIVE_WIDTH + FRAC_BITS) : PROD_W;
   localparam int ACC_W  = BASE_W + 2;

   localparam logic signed [ACC_W-1:0] ROUND   = ACC_W'(2 ** (FRAC_BITS - 1));
   localparam logic signed [ACC_W-1:0] DRV_MAX =
      {{(ACC_W - DRIVE_WIDTH + 1){1'b0}}, {(DRIVE_WIDTH - 1){1'b1}}};
   localparam logic signed [ACC_W-1:0] DRV_MIN = ~DRV_MAX;

   logic signed [GAIN_W:0]      gain_now_s;
   logic signed [GAIN_W:0]      gain_prev_s;
   logic signed [PROD_W-1:0]    prod_now;
   logic signed [PROD_W-1:0]    prod_prev;
   logic signed [ACC_W-1:0]     acc;
   logic signed [ACC_W-1:0]     scaled;

   // Error against the reference, one bit wider than the operands
   assign error = ERR_W'(reference) - ERR_W'(speed);

   // Incremental PI law with round-half-up before the shift
   always_comb begin
      gain_now_s  = {1'b0, gain_now};
      gain_prev_s = {1'b0, gain_prev};
      prod_now    = PROD_W'(gain_now_s) * PROD_W'(error);
      prod_prev   = PROD_W'(gain_prev_s) * PROD_W'(prev_error);
      acc         = (ACC_W'(prev_drive) <<< FRAC_BITS) + ACC_W'(prod_now)
                    - ACC_W'(prod_prev) + ROUND;
      scaled      = acc >>> FRAC_BITS;
      // Clamp to the drive range
      if (scaled > DRV_MAX) begin
         drive = DRV_MAX[DRIVE_WIDTH-1:0];
      end else if (scaled < DRV_MIN) begin
         drive = DRV_MIN[DRIVE_WIDTH-1:0];
      end else begin
         drive = scaled[DRIVE_WIDTH-1:0];
      end
   end

endmodule

@@ hw/rtl/dual_motor_pi_speed_loop.sv @@
// Dual-motor incremental PI speed loop with square-wave reference.
// An accepted request waits in the input register; one combinational pass
// of both PI channels, which closes the drive recurrence, feeds the result
// register. Throughput: one request per cycle while rsp_stall is low.
// Reset (synchronous): pipeline empty, phase and stored errors/drives zero,
// registers at ref_magnitude 0, gains 256, half_period 300.
module dual_motor_pi_speed_loop
   import dmpi_pkg::*;
#(
   parameter int FRAC_BITS   = 8,
   parameter int DRIVE_WIDTH = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   // configuration
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [CSR_IDX_W-1:0]          csr_index,
   input  logic [CSR_W-1:0]              csr_data,
   // requests
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [SPEED_W-1:0]     req_speed_a,
   input  logic signed [SPEED_W-1:0]     req_speed_b,
   input  logic                          req_enable,
   // results
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [REF_W-1:0]       rsp_reference,
   output logic signed [ERR_W-1:0]       rsp_error_a,
   output logic signed [ERR_W-1:0]       rsp_error_b,
   output logic signed [DRIVE_WIDTH-1:0] rsp_drive_a,
   output logic signed [DRIVE_WIDTH-1:0] rsp_drive_b
);

   // configuration registers
   logic [MAG_W-1:0]  ref_mag_ff;
   logic [GAIN_W-1:0] gain_now_ff;
   logic [GAIN_W-1:0] gain_prev_ff;
   logic [HALF_W-1:0] half_period_ff;

   // input register
   logic                      in_valid_ff;
   logic signed [SPEED_W-1:0] speed_a_ff;
   logic signed [SPEED_W-1:0] speed_b_ff;
   logic                      enable_ff;

   // loop state
   logic [TICK_W-1:0]             tick_ff;
   logic [TICK_W-1:0]             tick_in;
   logic                          last_enable_ff;
   logic signed [ERR_W-1:0]       prev_err_a_ff;
   logic signed [ERR_W-1:0]       prev_err_b_ff;
   logic signed [DRIVE_WIDTH-1:0] prev_drv_a_ff;
   logic signed [DRIVE_WIDTH-1:0] prev_drv_b_ff;

   // result register
   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;
   logic signed [REF_W-1:0]       ref_ff;
   logic signed [ERR_W-1:0]       err_a_ff;
   logic signed [ERR_W-1:0]       err_b_ff;
   logic signed [DRIVE_WIDTH-1:0] drv_a_ff;
   logic signed [DRIVE_WIDTH-1:0] drv_b_ff;

   logic                          advance;
   logic                          req_take;
   logic [TICK_W:0]               tick_inc;
   logic [TICK_W:0]               period;
   logic signed [REF_W-1:0]       ref_in;
   logic signed [ERR_W-1:0]       pe_a;
   logic signed [ERR_W-1:0]       pe_b;
   logic signed [DRIVE_WIDTH-1:0] pd_a;
   logic signed [DRIVE_WIDTH-1:0] pd_b;
   logic signed [ERR_W-1:0]       err_a;
   logic signed [ERR_W-1:0]       err_b;
   logic signed [DRIVE_WIDTH-1:0] drv_a;
   logic signed [DRIVE_WIDTH-1:0] drv_b;

   // handshake: move the held request on when the result slot frees
   assign csr_ready = 1'b1;
   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         ref_mag_ff     <= MAG_RESET;
         gain_now_ff    <= GAIN_RESET;
         gain_prev_ff   <= GAIN_RESET;
         half_period_ff <= HALF_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_REF_MAG:     ref_mag_ff     <= csr_data[MAG_W-1:0];
            CSR_GAIN_NOW:    gain_now_ff    <= csr_data[GAIN_W-1:0];
            CSR_GAIN_PREV:   gain_prev_ff   <= csr_data[GAIN_W-1:0];
            CSR_HALF_PERIOD: half_period_ff <= csr_data[HALF_W-1:0];
            default: ;
         endcase
      end
   end

   // capture the request
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         speed_a_ff <= req_speed_a;
         speed_b_ff <= req_speed_b;
         enable_ff  <= req_enable;
      end
   end

   // advance the phase while enabled, wrapping at twice the half period
   always_comb begin
      tick_inc = {1'b0, tick_ff} + (TICK_W + 1)'(1);
      period   = {1'b0, half_period_ff, 1'b0};
      if (!enable_ff) begin
         tick_in = tick_ff;
      end else if (tick_inc >= period) begin
         tick_in = '0;
      end else begin
         tick_in = tick_inc[TICK_W-1:0];
      end
      if (tick_in < TICK_W'(half_period_ff)) begin
         ref_in = REF_W'({1'b0, ref_mag_ff});
      end else begin
         ref_in = REF_W'(0) - REF_W'({1'b0, ref_mag_ff});
      end
      // drop stored history on a fresh enable
      pe_a = last_enable_ff ? prev_err_a_ff : '0;
      pe_b = last_enable_ff ? prev_err_b_ff : '0;
      pd_a = last_enable_ff ? prev_drv_a_ff : '0;
      pd_b = last_enable_ff ? prev_drv_b_ff : '0;
   end

   dmpi_chan #(
      .FRAC_BITS   (FRAC_BITS),
      .DRIVE_WIDTH (DRIVE_WIDTH)
   ) u_chan_a (
      .reference  (ref_in),
      .speed      (speed_a_ff),
      .prev_error (pe_a),
      .prev_drive (pd_a),
      .gain_now   (gain_now_ff),
      .gain_prev  (gain_prev_ff),
      .error      (err_a),
      .drive      (drv_a)
   );

   dmpi_chan #(
      .FRAC_BITS   (FRAC_BITS),
      .DRIVE_WIDTH (DRIVE_WIDTH)
   ) u_chan_b (
      .reference  (ref_in),
      .speed      (speed_b_ff),
      .prev_error (pe_b),
      .prev_drive (pd_b),
      .gain_now   (gain_now_ff),
      .gain_prev  (gain_prev_ff),
      .error      (err_b),
      .drive      (drv_b)
   );

   // update state per completed request; phase/history only while enabled
   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff        <= '0;
         last_enable_ff <= 1'b0;
         prev_err_a_ff  <= '0;
         prev_err_b_ff  <= '0;
         prev_drv_a_ff  <= '0;
         prev_drv_b_ff  <= '0;
      end else if (advance) begin
         last_enable_ff <= enable_ff;
         if (enable_ff) begin
            tick_ff       <= tick_in;
            prev_err_a_ff <= err_a;
            prev_err_b_ff <= err_b;
            prev_drv_a_ff <= drv_a;
            prev_drv_b_ff <= drv_b;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ref_ff   <= ref_in;
         err_a_ff <= enable_ff ? err_a : '0;
         err_b_ff <= enable_ff ? err_b : '0;
         drv_a_ff <= enable_ff ? drv_a : '0;
         drv_b_ff <= enable_ff ? drv_b : '0;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_reference = ref_ff;
   assign rsp_error_a   = err_a_ff;
   assign rsp_error_b   = err_b_ff;
   assign rsp_drive_a   = drv_a_ff;
   assign rsp_drive_b   = drv_b_ff;

endmodule
